FILE: rtl/core/btn_rpt_pkg.sv
// Shared constants and codes for the button auto-repeat generator.
`default_nettype none
package btn_rpt_pkg;
	localparam int NUM_BUTTONS = 32;
	localparam int BTN_W       = $clog2(NUM_BUTTONS);

	localparam int OP_W        = 2;
	localparam int BUTTON_W    = 5;
	localparam int REPEAT_W    = 5;
	localparam int REG_W       = 16;
	localparam int CD_W        = 17;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 8;

	localparam logic [OP_W-1:0] OP_PRESS   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 1'd1;

	localparam logic [REG_W-1:0] INITIAL_DELAY_RST = 16'd300;
	localparam logic [REG_W-1:0] REPEAT_PERIOD_RST = 16'd50;
endpackage
`default_nettype wire

FILE: rtl/core/button_auto_repeat_top.sv
// Button auto-repeat generator: press/release/tick words in, repeat words out.
// Press and release are handled in the idle state. A tick scans the buttons one per cycle,
// unless a stalled output holds the scan, through a single countdown update unit and a
// countdown memory with one write and one read port; input is not ready until the flush ends.
// A repeat word is held until the next firing button or the end of the scan sets its last flag.
// arst_n clears held flags, scan control and output valid; registers return to 300 and 50.
`default_nettype none
module button_auto_repeat_top
	import btn_rpt_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [REG_W-1:0]       cfg_data,
	// input words
	input  wire logic                   s_axis_tvalid,
	output      logic                   s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,   // [1:0] operation, [6:2] button
	// repeat words
	output      logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output      logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [4:0] repeat_button
	output      logic                   m_axis_tlast
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_UPD   = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;

	logic [1:0]            state_q;
	logic [REG_W-1:0]      delay_q;
	logic [REG_W-1:0]      period_q;
	logic [NUM_BUTTONS-1:0] held_q;
	logic [BTN_W-1:0]      idx_q;
	logic                  pend_valid_q;
	logic [BTN_W-1:0]      pend_btn_q;
	logic                  out_valid_q;
	logic [REPEAT_W-1:0]   out_btn_q;
	logic                  out_last_q;

	// countdown store; entries of buttons not held are never used
	logic [CD_W-1:0]       cd_mem [NUM_BUTTONS];
	logic [CD_W-1:0]       rd_q;

	logic [OP_W-1:0]       in_op;
	logic [BUTTON_W-1:0]   in_btn;
	logic                  in_accept;
	logic                  btn_ok;
	logic [BTN_W-1:0]      btn_idx;
	logic                  out_busy;
	logic                  cur_held;
	logic                  fire;
	logic                  stall;
	logic                  advance;
	logic                  scan_end;
	logic                  out_push;
	logic                  out_push_last;
	logic                  mem_we;
	logic [BTN_W-1:0]      mem_waddr;
	logic [CD_W-1:0]       mem_wdata;
	logic [BTN_W-1:0]      rd_addr;

	assign in_op     = s_axis_tdata[OP_W-1:0];
	assign in_btn    = s_axis_tdata[OP_W +: BUTTON_W];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign btn_ok    = (32'(in_btn) < 32'(NUM_BUTTONS));
	assign btn_idx   = BTN_W'(in_btn);

	// the output register is full and nobody takes it this cycle
	assign out_busy  = out_valid_q && !m_axis_tready;

	// shared update unit: one held countdown per cycle unless the scan is stalled
	assign cur_held  = held_q[idx_q];
	assign fire      = cur_held && (rd_q <= CD_W'(1));
	// a second firing needs the pending word moved out first
	assign stall     = (state_q == S_UPD) && fire && pend_valid_q && out_busy;
	assign advance   = (state_q == S_UPD) && !stall;
	assign scan_end  = (idx_q == BTN_W'(NUM_BUTTONS - 1));

	assign out_push_last = (state_q == S_FLUSH);
	assign out_push  = pend_valid_q && !out_busy &&
		(((state_q == S_UPD) && fire) || (state_q == S_FLUSH));

	// memory write: press loads delay + period, scan writes back reload or decrement
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd_q - CD_W'(1);
		if (state_q == S_IDLE) begin
			mem_waddr = btn_idx;
			mem_wdata = CD_W'(delay_q) + CD_W'(period_q);
			mem_we    = in_accept && (in_op == OP_PRESS) && btn_ok;
		end else if (advance && cur_held) begin
			mem_we = 1'b1;
			if (fire) begin
				mem_wdata = CD_W'(period_q);
			end
		end
	end

	// read the next button while the current one is written back
	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = '0;
		end else if (advance) begin
			rd_addr = idx_q + BTN_W'(1);
		end else begin
			rd_addr = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cd_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= cd_mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= INITIAL_DELAY_RST;
			period_q <= REPEAT_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INITIAL_DELAY: delay_q  <= cfg_data;
				REG_REPEAT_PERIOD: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// held flags: set on press, drop on release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (in_accept && btn_ok) begin
			if (in_op == OP_PRESS) begin
				held_q[btn_idx] <= 1'b1;
			end else if (in_op == OP_RELEASE) begin
				held_q[btn_idx] <= 1'b0;
			end
		end
	end

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_btn_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept && (in_op == OP_TICK)) begin
						idx_q   <= '0;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (advance) begin
						// hold the newest firing until we know whether it is the last
						if (fire) begin
							pend_valid_q <= 1'b1;
							pend_btn_q   <= idx_q;
						end
						idx_q <= idx_q + BTN_W'(1);
						if (scan_end) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (!out_busy) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_btn_q  <= REPEAT_W'(pend_btn_q);
			out_last_q <= out_push_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - REPEAT_W)'(0), out_btn_q};
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("pending repeat left over after a tick scan");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !scan_end) |=> ((state_q == S_UPD) && (idx_q == $past(idx_q) + BTN_W'(1))))
		else $error("scan index did not step by one");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && !out_push_last) |=> (REPEAT_W'(pend_btn_q) > out_btn_q))
		else $error("repeat words out of ascending order");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> ((state_q == S_UPD) && $stable(idx_q) && pend_valid_q))
		else $error("scan moved while the output was stalled");
`endif

endmodule
`default_nettype wire

FILE: test/button_auto_repeat_top_tb.sv
// Self-checking testbench for the button auto-repeat generator: scoreboard, stimulus, checks.
`timescale 1ns / 100ps

// Scoreboard: keeps its own copy of held flags, countdowns and registers, and a queue of the
// repeat words that accepted ticks are still owed.
class repeat_scoreboard;
	typedef struct packed {
		logic [btn_rpt_pkg::REPEAT_W-1:0] button;
		logic                             last;
	} repeat_t;

	logic [btn_rpt_pkg::REG_W-1:0] initial_delay;
	logic [btn_rpt_pkg::REG_W-1:0] repeat_period;
	bit   [btn_rpt_pkg::NUM_BUTTONS-1:0] held;
	logic [btn_rpt_pkg::CD_W-1:0] countdown [btn_rpt_pkg::NUM_BUTTONS];
	repeat_t owed_repeats [$];

	int errors;
	int presses, releases, ticks, ignored, reg_writes;
	int repeats_owed, repeats_seen, busiest_tick;

	function new();
		initial_delay = btn_rpt_pkg::INITIAL_DELAY_RST;
		repeat_period = btn_rpt_pkg::REPEAT_PERIOD_RST;
		held = '0;
		foreach (countdown[i]) countdown[i] = '0;
	endfunction

	function void set_reg(logic [btn_rpt_pkg::CFG_IDX_W-1:0] idx,
			logic [btn_rpt_pkg::REG_W-1:0] value);
		reg_writes++;
		case (idx)
			btn_rpt_pkg::REG_INITIAL_DELAY: initial_delay = value;
			btn_rpt_pkg::REG_REPEAT_PERIOD: repeat_period = value;
			default: ;
		endcase
	endfunction

	function int pending();
		return owed_repeats.size();
	endfunction

	// Apply one accepted input word and queue the repeats it causes.
	function void note_word(logic [btn_rpt_pkg::OP_W-1:0] op,
			logic [btn_rpt_pkg::BUTTON_W-1:0] btn);
		repeat_t fired [$];
		repeat_t r;
		case (op)
			btn_rpt_pkg::OP_PRESS: begin
				presses++;
				if (int'(btn) < btn_rpt_pkg::NUM_BUTTONS) begin
					held[btn] = 1'b1;
					countdown[btn] = {1'b0, initial_delay} + {1'b0, repeat_period};
				end
			end
			btn_rpt_pkg::OP_RELEASE: begin
				releases++;
				if (int'(btn) < btn_rpt_pkg::NUM_BUTTONS) begin
					held[btn] = 1'b0;
					countdown[btn] = '0;
				end
			end
			btn_rpt_pkg::OP_TICK: begin
				ticks++;
				for (int i = 0; i < btn_rpt_pkg::NUM_BUTTONS; i++) begin
					if (!held[i])
						continue;
					// a countdown at one or already at zero fires and reloads
					if (countdown[i] <= 1) begin
						countdown[i] = {1'b0, repeat_period};
						r.button = i[btn_rpt_pkg::REPEAT_W-1:0];
						r.last = 1'b0;
						fired.push_back(r);
					end else begin
						countdown[i] = countdown[i] - 1'b1;
					end
				end
				if (fired.size() > 0)
					fired[fired.size()-1].last = 1'b1;
				if (fired.size() > busiest_tick)
					busiest_tick = fired.size();
				repeats_owed += fired.size();
				foreach (fired[i]) owed_repeats.push_back(fired[i]);
			end
			default: ignored++;
		endcase
	endfunction

	// Compare one accepted repeat word with the oldest owed one.
	function void check_repeat(logic [btn_rpt_pkg::REPEAT_W-1:0] button, logic last);
		repeat_t exp;
		repeats_seen++;
		if (owed_repeats.size() == 0) begin
			$error("unexpected repeat word: repeat_button %0d last %0d", button, last);
			errors++;
			return;
		end
		exp = owed_repeats.pop_front();
		if (button !== exp.button) begin
			$error("repeat_button mismatch: expected %0d, actual %0d", exp.button, button);
			errors++;
		end
		if (last !== exp.last) begin
			$error("last mismatch: expected %0d, actual %0d", exp.last, last);
			errors++;
		end
	endfunction
endclass

module button_auto_repeat_top_tb;
	import btn_rpt_pkg::*;

	// operation code the block must ignore
	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

	// cycles to let a resultless tick finish its scan before touching registers
	localparam int SETTLE_CYCLES = NUM_BUTTONS + 8;
	// long receiver hold-off that backs the block up into its input
	localparam int RX_HOLD_CYCLES = 500;
	// input words to send over the whole run
	localparam int TOTAL_WORDS = 230;
	localparam int WORDS_PER_PHASE = 30;

	// register settings visited by the random part, extremes included
	localparam int NUM_PHASES = 7;
	localparam logic [REG_W-1:0] PHASE_DELAY [NUM_PHASES] =
		'{16'd1, 16'd0, 16'd4, 16'd0, 16'd3, 16'd65535, 16'd2};
	localparam logic [REG_W-1:0] PHASE_PERIOD [NUM_PHASES] =
		'{16'd2, 16'd3, 16'd1, 16'd0, 16'd5, 16'd65535, 16'd1};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [REG_W-1:0]      cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // [1:0] operation, [6:2] button
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // [4:0] repeat_button
	logic                  m_axis_tlast;

	repeat_scoreboard board;

	// idling controls shared by the stimulus and the receiver
	bit tx_idle_on;
	bit rx_stall_on;
	bit rx_hold_req;
	int words_sent;

	button_auto_repeat_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Gap length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one input word after an optional gap, hold it until accepted, then record it.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [BUTTON_W-1:0] btn);
		int gap;
		gap = tx_idle_on ? gap_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {1'b0, btn, op};
		do @(posedge clk); while (!s_axis_tready);
		board.note_word(op, btn);
		words_sent++;
	endtask

	// Write a register once the block has drained and finished any silent scan.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		board.set_reg(idx, value);
	endtask

	task automatic set_timing(input logic [REG_W-1:0] delay, input logic [REG_W-1:0] period);
		write_reg(REG_INITIAL_DELAY, delay);
		write_reg(REG_REPEAT_PERIOD, period);
	endtask

	// One random word: ticks dominate, buttons lean on a small group so releases
	// and re-presses hit held buttons often.
	task automatic random_word(input int focus);
		int r;
		logic [OP_W-1:0] op;
		logic [BUTTON_W-1:0] btn;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 2) == 0)
			btn = BUTTON_W'($urandom_range(0, NUM_BUTTONS - 1));
		else
			btn = BUTTON_W'($urandom_range(0, focus - 1));
		if (r < 45)
			op = OP_TICK;
		else if (r < 70)
			op = OP_PRESS;
		else if (r < 93)
			op = OP_RELEASE;
		else
			op = OP_IGNORED;
		send_word(op, btn);
	endtask

	// Receiver: accept with random stalls, and serve one long hold-off on request.
	initial begin : repeat_sink
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready = 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
			end
			if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = 1'b1;
				if (rx_stall_on && $urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
		end
	end

	// Check every repeat word at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_repeat(m_axis_tdata[REPEAT_W-1:0], m_axis_tlast);
	end

	// Stop a hung run; worst case is every tick firing all buttons into long stalls.
	initial begin : watchdog
		#40_000_000;
		$display("button_auto_repeat_top_tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int focus;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		tx_idle_on = 1'b0;
		rx_stall_on = 1'b0;
		rx_hold_req = 1'b0;
		words_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part.
		// Reset timing: a fresh press has 350 ticks to go, so nothing fires yet.
		send_word(OP_PRESS, 5'd9);
		send_word(OP_TICK, 5'd0);
		send_word(OP_RELEASE, 5'd9);
		// Zero delay and zero period: a held countdown sits at zero and fires every tick.
		set_timing(16'd0, 16'd0);
		send_word(OP_TICK, 5'd31);          // nothing held, tick gives nothing
		send_word(OP_PRESS, 5'd0);
		send_word(OP_PRESS, 5'd31);
		send_word(OP_TICK, 5'd0);           // 0, then 31 flagged last
		send_word(OP_TICK, 5'd31);
		send_word(OP_IGNORED, 5'd31);       // ignored operation leaves state alone
		send_word(OP_IGNORED, 5'd0);
		send_word(OP_TICK, 5'd0);
		send_word(OP_RELEASE, 5'd31);
		send_word(OP_RELEASE, 5'd5);        // release of a button never held
		send_word(OP_TICK, 5'd0);           // only 0, flagged last
		send_word(OP_RELEASE, 5'd0);
		send_word(OP_TICK, 5'd0);
		// Short delay: count down from three, then press again mid-count to restart.
		set_timing(16'd2, 16'd1);
		send_word(OP_PRESS, 5'd7);
		send_word(OP_TICK, 5'd0);
		send_word(OP_TICK, 5'd0);
		send_word(OP_PRESS, 5'd7);          // restart while held
		send_word(OP_TICK, 5'd0);
		send_word(OP_TICK, 5'd0);
		send_word(OP_TICK, 5'd0);           // fires
		send_word(OP_TICK, 5'd0);           // period of one fires again
		send_word(OP_RELEASE, 5'd7);

		// Full bank firing on every tick, with the receiver holding off so the block
		// backs up and stalls its input.
		set_timing(16'd0, 16'd0);
		tx_idle_on = 1'b1;
		rx_stall_on = 1'b1;
		for (int b = 0; b < NUM_BUTTONS; b++)
			send_word(OP_PRESS, BUTTON_W'(b));
		tx_idle_on = 1'b0;
		rx_hold_req = 1'b1;
		repeat (6) send_word(OP_TICK, BUTTON_W'($urandom_range(0, NUM_BUTTONS - 1)));
		tx_idle_on = 1'b1;
		for (int b = NUM_BUTTONS - 1; b >= 0; b--)
			send_word(OP_RELEASE, BUTTON_W'(b));

		// Random part: step through the timing settings, re-rolling idling now and then.
		phase = 0;
		while (words_sent < TOTAL_WORDS) begin
			set_timing(PHASE_DELAY[phase % NUM_PHASES], PHASE_PERIOD[phase % NUM_PHASES]);
			focus = ($urandom_range(0, 1) == 0) ? 4 : 12;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if ($urandom_range(0, 19) == 0) begin
					tx_idle_on = $urandom_range(0, 2) != 0;
					rx_stall_on = $urandom_range(0, 2) != 0;
				end
				random_word(focus);
			end
			phase++;
		end

		// Drain: drop valid, wait for every owed repeat, then let a last scan finish.
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d presses, %0d releases, %0d ticks, %0d ignored words",
			board.presses, board.releases, board.ticks, board.ignored);
		$display("checked %0d repeat words, up to %0d from one tick, over %0d reg writes",
			board.repeats_seen, board.busiest_tick, board.reg_writes);
		if (board.errors == 0)
			$display("button_auto_repeat_top_tb OK");
		else
			$display("button_auto_repeat_top_tb NOT OK");
		$finish;
	end
endmodule
